FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the velocity filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/dbvf_pkg.sv
// ----------------------------------------------------------------------------
// dbvf_pkg
// Types, constants and the biquad sum/saturate helper for the velocity filter.
// ----------------------------------------------------------------------------
package dbvf_pkg;

  // Default depth of each delay store
  localparam int DEF_MAX_DELAY_TICKS = 1024;

  // Fixed-point formats
  localparam int VEL_W          = 32;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 30;
  localparam int PROD_W         = VEL_W + COEF_W;
  localparam int ACC_W          = PROD_W + 4;
  localparam int TICKS_W        = 11;

  // Config port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Decoupling queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_FILTER_EN = 3'd0,
    REG_DELAY_EN  = 3'd1,
    REG_DELAY_TCK = 3'd2,
    REG_COEF_B0   = 3'd3,
    REG_COEF_B1   = 3'd4,
    REG_COEF_B2   = 3'd5,
    REG_COEF_A1   = 3'd6,
    REG_COEF_A2   = 3'd7
  } reg_idx_t;

  // Coefficient reset values, Q2.30
  localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd2463448;
  localparam logic signed [COEF_W-1:0] RST_B1 = 32'sd2463448;
  localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd0;
  localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd1068386503;
  localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd0;

  // Coefficient set handed to the filter
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // One beat between the delay front end and the filter back end
  typedef struct packed {
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
    logic                    clear;
  } q_item_t;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX      = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] Q_MIN      = ~Q_MAX;

  // Exact biquad sum, round to nearest (ties up), saturate to 32 bits
  function automatic logic signed [VEL_W-1:0] sat_sum(
    input logic signed [PROD_W-1:0] p_b0,
    input logic signed [PROD_W-1:0] p_b1,
    input logic signed [PROD_W-1:0] p_b2,
    input logic signed [PROD_W-1:0] p_a1,
    input logic signed [PROD_W-1:0] p_a2
  );
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shf;
    logic signed [VEL_W-1:0] res;
    acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
        - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_BIAS;
    shf = acc >>> COEF_FRAC_BITS;
    if (shf > Q_MAX) begin
      res = Q_MAX[VEL_W-1:0];
    end else if (shf < Q_MIN) begin
      res = Q_MIN[VEL_W-1:0];
    end else begin
      res = shf[VEL_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/delayed_biquad_velocity_filter.sv
// A beat passes the front-end output stage, the queue, the product register
//   and the result register. The back end takes no beat while it sums one,
//   by the biquad loop (y1 product register, sum, round, saturate into y1).
// The input side takes a beat every cycle until the 2-entry queue fills.
// Reset (rst, synchronous, active high) clears config, histories, fill and
//   head; the delay stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// delayed_biquad_velocity_filter
// Optional pure delay followed by an optional biquad on a velocity pair.
// ----------------------------------------------------------------------------
module delayed_biquad_velocity_filter import dbvf_pkg::*; #(
  parameter int MAX_DELAY_TICKS = DEF_MAX_DELAY_TICKS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEL_W-1:0] lin_velocity,
  input  logic signed [VEL_W-1:0] ang_velocity,
  input  logic                    clear_history,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VEL_W-1:0] lin_filtered,
  output logic signed [VEL_W-1:0] ang_filtered
);

  logic               filter_enable;
  logic               delay_enable;
  logic [TICKS_W-1:0] delay_ticks;
  coef_t              coef;
  reg_idx_t           reg_idx;
  logic               wr_en;

  logic               q_push_valid;
  logic               q_push_ready;
  q_item_t            q_push_item;
  logic               q_pop_valid;
  logic               q_pop_ready;
  q_item_t            q_pop_item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      delay_enable  <= 1'b0;
      delay_ticks   <= '0;
      coef.b0       <= RST_B0;
      coef.b1       <= RST_B1;
      coef.b2       <= RST_B2;
      coef.a1       <= RST_A1;
      coef.a2       <= RST_A2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER_EN: filter_enable <= pwdata[0];
        REG_DELAY_EN:  delay_enable  <= pwdata[0];
        REG_DELAY_TCK: delay_ticks   <= pwdata[TICKS_W-1:0];
        REG_COEF_B0:   coef.b0       <= pwdata;
        REG_COEF_B1:   coef.b1       <= pwdata;
        REG_COEF_B2:   coef.b2       <= pwdata;
        REG_COEF_A1:   coef.a1       <= pwdata;
        REG_COEF_A2:   coef.a2       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_FILTER_EN: prdata = {31'd0, filter_enable};
      REG_DELAY_EN:  prdata = {31'd0, delay_enable};
      REG_DELAY_TCK: prdata = {21'd0, delay_ticks};
      REG_COEF_B0:   prdata = coef.b0;
      REG_COEF_B1:   prdata = coef.b1;
      REG_COEF_B2:   prdata = coef.b2;
      REG_COEF_A1:   prdata = coef.a1;
      REG_COEF_A2:   prdata = coef.a2;
      default:       prdata = '0;
    endcase
  end

  // Delay front end
  dbvf_front #(
    .MAX_DELAY_TICKS(MAX_DELAY_TICKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .delay_enable (delay_enable),
    .delay_ticks  (delay_ticks),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .lin_velocity (lin_velocity),
    .ang_velocity (ang_velocity),
    .clear_history(clear_history),
    .push_valid   (q_push_valid),
    .push_ready   (q_push_ready),
    .push_item    (q_push_item)
  );

  // Decoupling queue
  dbvf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_item (q_push_item),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item)
  );

  // Biquad back end
  dbvf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .filter_enable(filter_enable),
    .coef         (coef),
    .pop_valid    (q_pop_valid),
    .pop_ready    (q_pop_ready),
    .pop_item     (q_pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lin_filtered (lin_filtered),
    .ang_filtered (ang_filtered)
  );

endmodule

FILE: rtl/dbvf_front.sv
// ----------------------------------------------------------------------------
// dbvf_front
// Accepts input beats, runs the shared lin/ang delay line and forwards the
// delayed pair with its clear flag toward the filter queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbvf_front import dbvf_pkg::*; #(
  parameter int MAX_DELAY_TICKS = DEF_MAX_DELAY_TICKS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    delay_enable,
  input  logic [TICKS_W-1:0]      delay_ticks,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEL_W-1:0] lin_velocity,
  input  logic signed [VEL_W-1:0] ang_velocity,
  input  logic                    clear_history,
  output logic                    push_valid,
  input  logic                    push_ready,
  output q_item_t                 push_item
);

  localparam int AW = (MAX_DELAY_TICKS > 1) ? $clog2(MAX_DELAY_TICKS) : 1;
  localparam int FW = $clog2(MAX_DELAY_TICKS + 1);

  typedef enum logic [1:0] {
    DL_PASS  = 2'd0,
    DL_FILL  = 2'd1,
    DL_SHIFT = 2'd2
  } dl_mode_t;

  logic [FW-1:0]          fill;
  logic [FW-1:0]          fill_next;
  logic [AW-1:0]          head;
  logic [AW-1:0]          head_next;
  logic [FW-1:0]          dly_len;
  logic [FW:0]            wsum;
  logic [AW-1:0]          wr_addr;
  dl_mode_t               mode;
  logic                   accept;
  logic                   mem_we;
  logic                   mem_re;

  logic signed [VEL_W-1:0] lin_mem [MAX_DELAY_TICKS];
  logic signed [VEL_W-1:0] ang_mem [MAX_DELAY_TICKS];
  logic signed [VEL_W-1:0] rd_lin;
  logic signed [VEL_W-1:0] rd_ang;

  logic                    s1_valid;
  logic signed [VEL_W-1:0] s1_lin;
  logic signed [VEL_W-1:0] s1_ang;
  logic                    s1_clear;
  logic                    s1_use_mem;

  assign in_ready = !s1_valid || push_ready;
  assign accept   = in_valid && in_ready;

  // Effective delay length, clamped to store depth
  assign dly_len = ({21'd0, delay_ticks} > 32'(MAX_DELAY_TICKS)) ?
                   FW'(MAX_DELAY_TICKS) : FW'({21'd0, delay_ticks});

  // Write slot: head + fill, wrapped once
  assign wsum    = (FW+1)'(head) + (FW+1)'(fill);
  assign wr_addr = (wsum >= (FW+1)'(MAX_DELAY_TICKS)) ?
                   AW'(wsum - (FW+1)'(MAX_DELAY_TICKS)) : AW'(wsum);

  // Classify the beat
  always_comb begin
    if (!delay_enable) begin
      mode = DL_PASS;
    end else if (fill < dly_len) begin
      mode = DL_FILL;
    end else if (fill != '0) begin
      mode = DL_SHIFT;
    end else begin
      mode = DL_PASS;
    end
  end

  // Line bookkeeping
  always_comb begin
    fill_next = fill;
    head_next = head;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (mode)
      DL_PASS: begin
      end
      DL_FILL: begin
        mem_we    = accept;
        fill_next = accept ? fill + FW'(1) : fill;
      end
      DL_SHIFT: begin
        mem_we = accept;
        mem_re = accept;
        if (accept) begin
          head_next = (head == AW'(MAX_DELAY_TICKS - 1)) ? '0 : head + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      head <= '0;
    end else begin
      fill <= fill_next;
      head <= head_next;
    end
  end

  // Delay stores, read-first on a shared slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lin_mem[wr_addr] <= lin_velocity;
      ang_mem[wr_addr] <= ang_velocity;
    end
    if (mem_re) begin
      rd_lin <= lin_mem[head];
      rd_ang <= ang_mem[head];
    end
  end

  // Output stage toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lin     <= (mode == DL_FILL) ? '0 : lin_velocity;
      s1_ang     <= (mode == DL_FILL) ? '0 : ang_velocity;
      s1_clear   <= clear_history;
      s1_use_mem <= (mode == DL_SHIFT);
    end
  end

  assign push_valid      = s1_valid;
  assign push_item.lin   = s1_use_mem ? rd_lin : s1_lin;
  assign push_item.ang   = s1_use_mem ? rd_ang : s1_ang;
  assign push_item.clear = s1_clear;

  // Checks
  `ASSERT_CLK(a_fill_bound, 32'(fill) <= 32'(MAX_DELAY_TICKS), "delay fill above depth")
  `ASSERT_CLK(a_head_bound, 32'(head) < 32'(MAX_DELAY_TICKS), "delay head out of range")
  `ASSERT_CLK(a_line_hold, !accept |=> ($stable(fill) && $stable(head)), "line moved without beat")

endmodule

FILE: rtl/dbvf_queue.sv
// ----------------------------------------------------------------------------
// dbvf_queue
// Short FIFO between the delay front end and the filter back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbvf_queue import dbvf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Checks
  `ASSERT_CLK(a_cnt_bound, 32'(count) <= 32'(QUEUE_DEPTH), "queue count above depth")
  `ASSERT_CLK(a_cnt_up, (push && !pop) |=> (count == $past(count) + CW'(1)), "bad count on push")
  `ASSERT_CLK(a_cnt_dn, (pop && !push) |=> (count == $past(count) - CW'(1)), "bad count on pop")

endmodule

FILE: rtl/dbvf_back.sv
// ----------------------------------------------------------------------------
// dbvf_back
// Two-channel direct-form-I biquad (or bypass when disabled): product register,
// then exact sum, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbvf_back import dbvf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    filter_enable,
  input  coef_t                   coef,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  q_item_t                 pop_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VEL_W-1:0] lin_filtered,
  output logic signed [VEL_W-1:0] ang_filtered
);

  logic                    busy;
  logic                    take;
  logic signed [VEL_W-1:0] ch_in  [2];
  logic signed [VEL_W-1:0] ch_res [2];

  assign pop_ready = !busy && (!out_valid || out_ready);
  assign take      = pop_valid && pop_ready;
  assign ch_in[0]  = pop_item.lin;
  assign ch_in[1]  = pop_item.ang;

  // Beat control: take, then the summing state (busy)
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= take;
      if (busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-channel datapath
  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic signed [VEL_W-1:0]  u1, u2, y1, y2;
    logic signed [VEL_W-1:0]  h_u1, h_u2, h_y1, h_y2;
    logic signed [VEL_W-1:0]  u_r;
    logic signed [VEL_W-1:0]  y;
    logic signed [VEL_W-1:0]  res_r;
    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;

    // Clear zeroes the histories seen by this beat
    assign h_u1 = pop_item.clear ? '0 : u1;
    assign h_u2 = pop_item.clear ? '0 : u2;
    assign h_y1 = pop_item.clear ? '0 : y1;
    assign h_y2 = pop_item.clear ? '0 : y2;

    // Product stage
    always_ff @(posedge clk) begin
      if (take) begin
        p_b0 <= coef.b0 * ch_in[ch];
        p_b1 <= coef.b1 * h_u1;
        p_b2 <= coef.b2 * h_u2;
        p_a1 <= coef.a1 * h_y1;
        p_a2 <= coef.a2 * h_y2;
        u_r  <= ch_in[ch];
      end
    end

    assign y = sat_sum(p_b0, p_b1, p_b2, p_a1, p_a2);

    // Histories
    always_ff @(posedge clk) begin
      if (rst) begin
        u1 <= '0;
        u2 <= '0;
        y1 <= '0;
        y2 <= '0;
      end else if (take && pop_item.clear) begin
        u1 <= '0;
        u2 <= '0;
        y1 <= '0;
        y2 <= '0;
      end else if (busy && filter_enable) begin
        u1 <= u_r;
        u2 <= u1;
        y1 <= y;
        y2 <= y1;
      end
    end

    // Result register
    always_ff @(posedge clk) begin
      if (busy) begin
        res_r <= filter_enable ? y : u_r;
      end
    end

    assign ch_res[ch] = res_r;
  end

  assign lin_filtered = ch_res[0];
  assign ang_filtered = ch_res[1];

  // Checks
  `ASSERT_CLK(a_two_phase, busy |=> !busy, "filter took a beat while summing")
  `ASSERT_CLK(a_result_due, busy |=> out_valid, "sum cycle left no result")
  `ASSERT_CLK(a_result_src, $rose(out_valid) |-> $past(busy), "result without a sum cycle")

endmodule
